@@ hw/rtl/pmdc_pkg.sv @@
// Shared types and constants for the PID motor duty controller.
package pmdc_pkg;

    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 15;
    localparam int DUTY_W     = 7;
    localparam int CTRL_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int CTRL_MAX = 32767;
    localparam int CTRL_MIN = -32768;

    // trunc(m / 300) for m <= 32768 as (m * DUTY_RECIP) >> DUTY_SHIFT, exact over that range
    localparam int DUTY_DIVISOR = 300;
    localparam int DUTY_SHIFT   = 24;
    localparam int DUTY_RECIP   = (1 << DUTY_SHIFT) / DUTY_DIVISOR + 1;
    localparam int MAG_W        = CTRL_W + 1;
    localparam int QPROD_W      = MAG_W + 16;

    localparam logic signed [GAIN_W-1:0] RST_KP       = 16'sd1;
    localparam logic signed [GAIN_W-1:0] RST_KI       = 16'sd1;
    localparam logic signed [GAIN_W-1:0] RST_KD       = 16'sd1;
    localparam logic [LIMIT_W-1:0]       RST_LIMIT    = 15'd25000;
    localparam logic [DUTY_W-1:0]        RST_CEILING  = 7'd100;
    localparam logic [DUTY_W-1:0]        RST_DEADBAND = 7'd35;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP       = 3'd0,
        CFG_KI       = 3'd1,
        CFG_KD       = 3'd2,
        CFG_LIMIT    = 3'd3,
        CFG_CEILING  = 3'd4,
        CFG_DEADBAND = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DUTY_W-1:0] ceiling;
        logic [DUTY_W-1:0] deadband;
    } t_duty_cfg;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              forward;
    } t_duty_res;

endpackage

@@ hw/rtl/pmdc_duty.sv @@
// Control value to duty magnitude and direction: divide by 300, cap, deadband.
module pmdc_duty
    import pmdc_pkg::*;
(
    input  logic signed [CTRL_W-1:0] i_control,
    input  t_duty_cfg                i_cfg,
    output t_duty_res                o_res
);

    logic [MAG_W-1:0]   w_mag;
    logic [QPROD_W-1:0] w_qprod;
    logic [DUTY_W-1:0]  w_quot;
    logic [DUTY_W-1:0]  w_capped;

    // magnitude of the control value; -32768 needs the extra bit
    assign w_mag = i_control[CTRL_W-1] ? (MAG_W'(0) - MAG_W'(i_control))
                                       : MAG_W'(i_control);

    // quotient never exceeds 109, so it fits the duty width
    assign w_qprod = QPROD_W'(w_mag) * QPROD_W'(DUTY_RECIP);
    assign w_quot  = w_qprod[DUTY_SHIFT +: DUTY_W];

    assign w_capped = (w_quot > i_cfg.ceiling) ? i_cfg.ceiling : w_quot;

    always_comb begin
        o_res.forward = !i_control[CTRL_W-1] && (w_quot != '0);
        o_res.duty    = (w_capped < i_cfg.deadband) ? '0 : w_capped;
    end

endmodule

@@ hw/rtl/pid_motor_duty_controller.sv @@
// PID motor duty controller: integral clamp, saturated control, duty and direction.
//
// channel   dir  handshake                       payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready rate_sample
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready control_value, duty_value, direction_forward
// cfg       in   i_cfg_we (no ready)             gain/limit/duty registers by index
//
// One word per clock sustained while m_axis does not stall; four register stages (input,
// product, sum, output), and an accepted word moves through them in that order to m_axis.
// The error history and the integral update at the input register, so samples may follow
// back to back. Per-stage valid bits let empty stages fill while the output stalls.
// i_rst_n is synchronous, active low: clears state, valids and restores register defaults.
module pid_motor_duty_controller
    import pmdc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [SAMPLE_WIDTH-1:0] rate_sample, zero padded to bytes
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [15:0] control_value, [22:16] duty_value, [23] direction_forward
    output logic [23:0]                         o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]               i_cfg_data
);

    localparam int SUM_W  = ((SAMPLE_WIDTH > CTRL_W) ? SAMPLE_WIDTH : CTRL_W) + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = GAIN_W + SUM_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(CTRL_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(CTRL_MIN);

    // configuration
    logic signed [GAIN_W-1:0] r_kp, r_ki, r_kd;
    logic [LIMIT_W-1:0]       r_limit;
    t_duty_cfg                r_duty_cfg;

    // controller state
    logic signed [SAMPLE_WIDTH-1:0] r_prev_err;
    logic signed [CTRL_W-1:0]       r_integral;

    // pipeline
    logic                           r_a_vld, r_b_vld, r_c_vld, r_o_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_a_err;
    logic signed [SUM_W-1:0]        r_a_sum;
    logic signed [DIFF_W-1:0]       r_a_diff;
    logic signed [PROD_W-1:0]       r_b_pp, r_b_pi, r_b_pd;
    logic signed [CTRL_W-1:0]       r_c_ctrl;
    logic signed [CTRL_W-1:0]       r_o_ctrl;
    t_duty_res                      r_o_res;

    logic                           w_a_rdy, w_b_rdy, w_c_rdy, w_o_rdy, w_accept;
    logic signed [SAMPLE_WIDTH-1:0] w_err;
    logic signed [SUM_W-1:0]        w_sum, w_lim_pos, w_lim_neg;
    logic signed [CTRL_W-1:0]       n_integral;
    logic signed [ACC_W-1:0]        w_acc;
    logic signed [CTRL_W-1:0]       n_ctrl;
    t_duty_res                      w_duty;

    assign w_o_rdy  = !r_o_vld || i_m_axis_tready;
    assign w_c_rdy  = !r_c_vld || w_o_rdy;
    assign w_b_rdy  = !r_b_vld || w_c_rdy;
    assign w_a_rdy  = !r_a_vld || w_b_rdy;
    assign w_accept = i_s_axis_tvalid && w_a_rdy;

    assign o_s_axis_tready = w_a_rdy;
    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {r_o_res.forward, r_o_res.duty, r_o_ctrl};

    assign w_err     = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign w_sum     = SUM_W'(w_err) + SUM_W'(r_integral);
    assign w_lim_pos = SUM_W'(signed'({1'b0, r_limit}));
    assign w_lim_neg = -w_lim_pos;

    // stored integral is clamped; the unclamped sum feeds the integral term
    always_comb begin
        if (w_sum > w_lim_pos) begin
            n_integral = w_lim_pos[CTRL_W-1:0];
        end else if (w_sum < w_lim_neg) begin
            n_integral = w_lim_neg[CTRL_W-1:0];
        end else begin
            n_integral = w_sum[CTRL_W-1:0];
        end
    end

    assign w_acc = ACC_W'(r_b_pp) + ACC_W'(r_b_pi) + ACC_W'(r_b_pd);

    always_comb begin
        if (w_acc > SAT_HI) begin
            n_ctrl = SAT_HI[CTRL_W-1:0];
        end else if (w_acc < SAT_LO) begin
            n_ctrl = SAT_LO[CTRL_W-1:0];
        end else begin
            n_ctrl = w_acc[CTRL_W-1:0];
        end
    end

    pmdc_duty u_duty (
        .i_control (r_c_ctrl),
        .i_cfg     (r_duty_cfg),
        .o_res     (w_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp                <= RST_KP;
            r_ki                <= RST_KI;
            r_kd                <= RST_KD;
            r_limit             <= RST_LIMIT;
            r_duty_cfg.ceiling  <= RST_CEILING;
            r_duty_cfg.deadband <= RST_DEADBAND;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KP:       r_kp                <= i_cfg_data;
                CFG_KI:       r_ki                <= i_cfg_data;
                CFG_KD:       r_kd                <= i_cfg_data;
                CFG_LIMIT:    r_limit             <= i_cfg_data[LIMIT_W-1:0];
                CFG_CEILING:  r_duty_cfg.ceiling  <= i_cfg_data[DUTY_W-1:0];
                CFG_DEADBAND: r_duty_cfg.deadband <= i_cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integral <= '0;
            r_a_vld    <= 1'b0;
            r_b_vld    <= 1'b0;
            r_c_vld    <= 1'b0;
            r_o_vld    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_prev_err <= w_err;
                r_integral <= n_integral;
            end
            if (w_a_rdy) r_a_vld <= i_s_axis_tvalid;
            if (w_b_rdy) r_b_vld <= r_a_vld;
            if (w_c_rdy) r_c_vld <= r_b_vld;
            if (w_o_rdy) r_o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_err  <= w_err;
            r_a_sum  <= w_sum;
            r_a_diff <= DIFF_W'(w_err) - DIFF_W'(r_prev_err);
        end
        if (r_a_vld && w_b_rdy) begin
            r_b_pp <= PROD_W'(r_kp) * PROD_W'(r_a_err);
            r_b_pi <= PROD_W'(r_ki) * PROD_W'(r_a_sum);
            r_b_pd <= PROD_W'(r_kd) * PROD_W'(r_a_diff);
        end
        if (r_b_vld && w_c_rdy) begin
            r_c_ctrl <= n_ctrl;
        end
        if (r_c_vld && w_o_rdy) begin
            r_o_ctrl <= r_c_ctrl;
            r_o_res  <= w_duty;
        end
    end

    // stored integral stays inside the clamp after every word
    a_integral_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_integral <= signed'({1'b0, r_limit}) &&
                      r_integral >= -signed'({1'b0, r_limit})))
        else $error("integral outside clamp");

    a_duty_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_vld |-> (r_o_res.duty <= r_duty_cfg.ceiling))
        else $error("duty above ceiling");

    // forward needs a control value of at least one divisor step
    a_forward_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_res.forward) |->
            (!r_o_ctrl[CTRL_W-1] && r_o_ctrl >= CTRL_W'(DUTY_DIVISOR)))
        else $error("forward with nonpositive duty");

endmodule

@@ sim/tb.sv @@
// Testbench for the PID motor duty controller: stream stimulus, predictor and word checks.
module tb;
    import pmdc_pkg::*;

    localparam int PIPE_DEPTH  = 4;
    localparam int PHASE_WORDS = 154;
    localparam int N_PHASES    = 8;
    localparam int N_DIR       = 20;

    // indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [CTRL_W-1:0] ctrl;
        logic [DUTY_W-1:0] duty;
        logic              fwd;
    } t_pid_result;

    typedef struct packed {
        logic [15:0] sample;
        bit          typed;
        t_pid_result want;
    } t_dir_row;

    // starts from reset state; rows with typed set carry a hand-worked result
    localparam t_dir_row DIRECTED_ROWS [N_DIR] = '{
        '{16'sd0,      1'b1, '{16'sd0,      7'd0,   1'b0}},
        '{16'sd32767,  1'b1, '{16'sd32767,  7'd100, 1'b1}},
        '{16'h8000,    1'b1, '{16'h8000,    7'd100, 1'b0}},
        '{16'h8000,    1'b1, '{16'h8000,    7'd100, 1'b0}},
        '{16'sd0,      1'b1, '{16'sd7768,   7'd0,   1'b1}},
        '{16'sd0,      1'b1, '{-16'sd25000, 7'd83,  1'b0}},
        '{16'sd25000,  1'b1, '{16'sd32767,  7'd100, 1'b1}},
        '{-16'sd1,     1'b0, '0},
        '{16'sd1,      1'b0, '0},
        '{16'sd300,    1'b0, '0},
        '{-16'sd300,   1'b0, '0},
        '{16'h5555,    1'b0, '0},
        '{16'hAAAA,    1'b0, '0},
        '{16'sd10500,  1'b0, '0},
        '{-16'sd10500, 1'b0, '0},
        '{16'sd32767,  1'b0, '0},
        '{16'sd32767,  1'b0, '0},
        '{16'sd32767,  1'b0, '0},
        '{16'sd0,      1'b0, '0},
        '{16'h8000,    1'b0, '0}
    };

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata  = '0;  // [15:0] rate_sample
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [23:0]           o_m_axis_tdata;        // [15:0] control, [22:16] duty, [23] forward
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    // predictor copy of registers and state
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       integ_limit;
    logic [DUTY_W-1:0]        duty_cap;
    logic [DUTY_W-1:0]        duty_floor;
    longint                   prev_err;
    longint                   integ_acc;

    t_pid_result duty_expect[$];
    int          mismatches = 0;
    int          src_mode   = 0;
    int          sink_mode  = 0;
    int          stall_left = 0;
    logic [15:0] last_sample = '0;

    pid_motor_duty_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_pid_result predict_duty(input logic signed [15:0] sample);
        longint err, sum, diff, ctrl, duty, gp, gi, gd, lim, cap, floor_v;
        bit fwd;
        t_pid_result r;
        err     = sample;
        gp      = gain_p;
        gi      = gain_i;
        gd      = gain_d;
        lim     = integ_limit;
        cap     = duty_cap;
        floor_v = duty_floor;
        sum  = integ_acc + err;
        diff = err - prev_err;
        // integral term uses the sum before its clamp
        ctrl = gp * err + gi * sum + gd * diff;
        if (ctrl > CTRL_MAX) ctrl = CTRL_MAX;
        if (ctrl < CTRL_MIN) ctrl = CTRL_MIN;
        duty = ctrl / DUTY_DIVISOR;
        fwd  = duty > 0;
        if (!fwd) duty = -duty;
        if (duty > cap) duty = cap;
        if (duty < floor_v) duty = 0;
        if (sum > lim) sum = lim;
        if (sum < -lim) sum = -lim;
        integ_acc = sum;
        prev_err  = err;
        r.ctrl = ctrl[CTRL_W-1:0];
        r.duty = duty[DUTY_W-1:0];
        r.fwd  = fwd;
        return r;
    endfunction

    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 11))
            0:       v = $urandom_range(0, 1) ? 32767 : -32768;
            1:       v = $signed(last_sample);   // repeats drive the integral to its clamp
            2, 3, 4: v = int'($urandom);
            5, 6, 7: v = int'($urandom_range(0, 800)) - 400;
            default: v = int'($urandom_range(0, 8000)) - 4000;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'(int'($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    // call at a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        case (idx)
            CFG_KP:       gain_p      = d;
            CFG_KI:       gain_i      = d;
            CFG_KD:       gain_d      = d;
            CFG_LIMIT:    integ_limit = d[LIMIT_W-1:0];
            CFG_CEILING:  duty_cap    = d[DUTY_W-1:0];
            CFG_DEADBAND: duty_floor  = d[DUTY_W-1:0];
            default: ;
        endcase
    endtask

    task automatic feed_sample(input logic [15:0] s, input bit typed, input t_pid_result want);
        t_pid_result got;
        if (src_mode != 0 && $urandom_range(0, src_mode == 1 ? 15 : 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        do @(posedge i_clk); while (!o_s_axis_tready);
        got = predict_duty(s);
        duty_expect.push_back(typed ? want : got);
        last_sample = s;
    endtask

    // drop valid, wait for every expected word, then let the pipe empty
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        i_cfg_we        <= 1'b0;
        while (duty_expect.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic check_word(input logic [23:0] w);
        t_pid_result want;
        if (duty_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", w);
        end else begin
            want = duty_expect.pop_front();
            if (w[15:0] !== want.ctrl || w[22:16] !== want.duty || w[23] !== want.fwd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: ctrl exp %0d got %0d, duty exp %0d got %0d, fwd exp %0b got %0b",
                             $signed(want.ctrl), $signed(w[15:0]), want.duty, w[22:16],
                             want.fwd, w[23]);
            end
        end
    endtask

    // result side: check accepted words, random stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left      <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_word(o_m_axis_tdata);
            if (stall_left != 0) begin
                stall_left      <= stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else if (sink_mode != 0 && $urandom_range(0, sink_mode == 1 ? 15 : 3) == 0) begin
                stall_left      <= $urandom_range(0, 8);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        gain_p      = RST_KP;
        gain_i      = RST_KI;
        gain_d      = RST_KD;
        integ_limit = RST_LIMIT;
        duty_cap    = RST_CEILING;
        duty_floor  = RST_DEADBAND;
        prev_err    = 0;
        integ_acc   = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_mode  = 1;
        sink_mode = 1;
        for (int r = 0; r < N_DIR; r++)
            feed_sample(DIRECTED_ROWS[r].sample, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    // zero gains, masked upper data bits, dead indexes
                    write_reg(CFG_KP, 16'd0);
                    write_reg(CFG_KI, 16'd0);
                    write_reg(CFG_KD, 16'd0);
                    write_reg(CFG_LIMIT, 16'hFFFF);
                    write_reg(CFG_CEILING, 16'hFFFF);
                    write_reg(CFG_DEADBAND, 16'hFF80);
                    write_reg(CFG_SPARE_A, 16'($urandom));
                    write_reg(CFG_SPARE_B, 16'($urandom));
                end
                1: begin
                    write_reg(CFG_KP, 16'h7FFF);
                    write_reg(CFG_KI, 16'h8000);
                    write_reg(CFG_KD, 16'hFFFF);
                    write_reg(CFG_LIMIT, 16'd0);
                    write_reg(CFG_CEILING, 16'd127);
                    write_reg(CFG_DEADBAND, 16'd0);
                end
                2: begin
                    // ceiling below deadband: duty always zero
                    write_reg(CFG_KP, 16'h8000);
                    write_reg(CFG_KI, 16'h7FFF);
                    write_reg(CFG_KD, 16'h7FFF);
                    write_reg(CFG_LIMIT, 16'd32767);
                    write_reg(CFG_CEILING, 16'd0);
                    write_reg(CFG_DEADBAND, 16'd127);
                end
                3: begin
                    write_reg(CFG_KP, 16'd1);
                    write_reg(CFG_KI, 16'd0);
                    write_reg(CFG_KD, 16'd0);
                    write_reg(CFG_LIMIT, 16'd100);
                    write_reg(CFG_CEILING, 16'd127);
                    write_reg(CFG_DEADBAND, 16'd1);
                end
                default: begin
                    write_reg(CFG_KP, pick_gain());
                    write_reg(CFG_KI, pick_gain());
                    write_reg(CFG_KD, pick_gain());
                    write_reg(CFG_LIMIT, 16'($urandom_range(0, 32767)));
                    write_reg(CFG_CEILING, 16'($urandom_range(0, 127)));
                    write_reg(CFG_DEADBAND, 16'($urandom_range(0, 40)));
                    if ($urandom_range(0, 1)) write_reg(CFG_SPARE_B, 16'($urandom));
                end
            endcase
            i_cfg_we <= 1'b0;
            // no idling in the last phase
            src_mode  = (ph == N_PHASES - 1) ? 0 : $urandom_range(0, 2);
            sink_mode = (ph == N_PHASES - 1) ? 0 : $urandom_range(0, 2);
            repeat (PHASE_WORDS) feed_sample(pick_sample(), 1'b0, '0);
        end

        settle();
        mismatches += duty_expect.size();
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
